FILE: sv/forward_row_box_blur_assert.svh
// Assertion macros for the forward row box blur RTL, used by the sequencer fbb_ctrl.
`ifndef FORWARD_ROW_BOX_BLUR_ASSERT_SVH
`define FORWARD_ROW_BOX_BLUR_ASSERT_SVH

`ifndef SYNTHESIS
`define FBB_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("fbb assertion failed");
`define FBB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fbb assertion failed");
`else
`define FBB_ASSERT(label, prop)
`define FBB_ASSERT_NEXT(label, ante, cons)
`endif

`endif

FILE: sv/fbb_pkg.sv
// Constants, types and register codes for the forward row box blur.
package fbb_pkg;

    localparam int MAX_WINDOW    = 32;
    localparam int MAX_ROW_WIDTH = 4096;

    localparam int PIX_W    = 8;
    localparam int CHANNELS = 3;
    localparam int TDATA_W  = PIX_W * CHANNELS;

    localparam int ADDR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int FILL_W = $clog2(MAX_WINDOW + 1);
    localparam int COL_W  = (MAX_ROW_WIDTH > 1) ? $clog2(MAX_ROW_WIDTH) : 1;
    localparam int ROW_W  = $clog2(MAX_ROW_WIDTH + 1);
    localparam int SUM_W  = $clog2(MAX_WINDOW * 255 + 1);

    // reciprocal scale: 2^k >= 2^SUM_W * MAX_WINDOW keeps the quotient exact
    localparam int RECIP_SHIFT = SUM_W + ADDR_W;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int PROD_W      = SUM_W + RECIP_W;

    // configuration port
    localparam int WIN_CFG_W  = 6;
    localparam int ROW_CFG_W  = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW    = 1'b1;

    localparam int WIN_RESET = (8 > MAX_WINDOW) ? MAX_WINDOW : 8;
    localparam int ROW_RESET = (640 > MAX_ROW_WIDTH) ? MAX_ROW_WIDTH : 640;

    typedef struct packed {
        logic                wr_en;
        logic [ADDR_W-1:0]   wr_addr;
        logic                rd_en;
        logic [ADDR_W-1:0]   rd_addr;
        logic                add_in;
        logic                sub_out;
        logic                load_prod;
        logic                bypass;
        logic                clear;
        logic [RECIP_W-1:0]  recip;
    } lane_ctrl_t;

    typedef struct packed {
        logic load;
        logic row_end;
    } out_ctrl_t;

endpackage

FILE: sv/fbb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fbb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                       clk,
    input  logic                                       wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                           wr_data,
    input  logic                                       rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                           rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: sv/fbb_lane.sv
// One colour channel: pending-pixel store, running sum and reciprocal divide.
module fbb_lane (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [fbb_pkg::PIX_W-1:0]      pix,
    input  fbb_pkg::lane_ctrl_t            ctrl,
    output logic [fbb_pkg::PIX_W-1:0]      quot
);

    logic [fbb_pkg::SUM_W-1:0]  sum_reg;
    logic [fbb_pkg::SUM_W-1:0]  sum_next;
    logic [fbb_pkg::SUM_W-1:0]  sum_plus;
    logic [fbb_pkg::SUM_W-1:0]  operand;
    logic [fbb_pkg::PROD_W-1:0] prod_reg;
    logic [fbb_pkg::PIX_W-1:0]  pix_reg;
    logic [fbb_pkg::PIX_W-1:0]  rd_data;
    logic [fbb_pkg::PIX_W-1:0]  pop_val;

    fbb_ram #(
        .WIDTH (fbb_pkg::PIX_W),
        .DEPTH (fbb_pkg::MAX_WINDOW)
    ) u_store (
        .clk     (clk),
        .wr_en   (ctrl.wr_en),
        .wr_addr (ctrl.wr_addr),
        .wr_data (pix),
        .rd_en   (ctrl.rd_en),
        .rd_addr (ctrl.rd_addr),
        .rd_data (rd_data)
    );

    assign sum_plus = sum_reg + fbb_pkg::SUM_W'(pix);
    assign operand  = ctrl.add_in ? sum_plus : sum_reg;
    // oldest pixel written in the same cycle it was read: take the held copy
    assign pop_val  = ctrl.bypass ? pix_reg : rd_data;

    always_comb
    begin
        sum_next = sum_reg;
        if (ctrl.clear)
        begin
            sum_next = '0;
        end
        else if (ctrl.add_in)
        begin
            sum_next = sum_plus;
        end
        else if (ctrl.sub_out)
        begin
            sum_next = sum_reg - fbb_pkg::SUM_W'(pop_val);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.add_in)
        begin
            pix_reg <= pix;
        end
        if (ctrl.load_prod)
        begin
            prod_reg <= fbb_pkg::PROD_W'(operand) * fbb_pkg::PROD_W'(ctrl.recip);
        end
    end

    assign quot = prod_reg[fbb_pkg::RECIP_SHIFT +: fbb_pkg::PIX_W];

endmodule

FILE: sv/fbb_merge.sv
// Output stage: joins the three channel quotients into one result register.
module fbb_merge (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic [fbb_pkg::CHANNELS-1:0][fbb_pkg::PIX_W-1:0] quot,
    input  fbb_pkg::out_ctrl_t                            ctrl,
    output logic                                          room,
    output logic                                          m_tvalid,
    input  logic                                          m_tready,
    output logic [fbb_pkg::TDATA_W-1:0]                   m_tdata,
    output logic                                          m_tlast
);

    logic                          valid_reg;
    logic                          valid_next;
    logic [fbb_pkg::TDATA_W-1:0]   data_reg;
    logic                          last_reg;

    assign room = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (ctrl.load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            data_reg <= quot;
            last_reg <= ctrl.row_end;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

endmodule

FILE: sv/fbb_ctrl.sv
// Row sequencer: config registers, store pointers, fill count and flush.
`include "forward_row_box_blur_assert.svh"

module fbb_ctrl (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic                                 cfg_we,
    input  logic [fbb_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [fbb_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                 room,
    output fbb_pkg::lane_ctrl_t                  lane_ctrl,
    output fbb_pkg::out_ctrl_t                   out_ctrl
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_POP  = 3'b010,
        S_READ = 3'b100
    } state_t;

    localparam logic [fbb_pkg::CFG_IDX_W-1:0] CFG_WINDOW_SEL = fbb_pkg::CFG_WINDOW;
    localparam logic [fbb_pkg::CFG_IDX_W-1:0] CFG_ROW_SEL    = fbb_pkg::CFG_ROW;

    state_t                         state_reg, state_next;
    logic [fbb_pkg::FILL_W-1:0]     win_reg, win_next;
    logic [fbb_pkg::ROW_W-1:0]      row_reg, row_next;
    logic [fbb_pkg::COL_W-1:0]      col_reg, col_next;
    logic [fbb_pkg::FILL_W-1:0]     fill_reg, fill_next;
    logic [fbb_pkg::ADDR_W-1:0]     wp_reg, wp_next;
    logic [fbb_pkg::ADDR_W-1:0]     rp_reg, rp_next;
    logic                           last_reg, last_next;
    logic                           end_reg, end_next;
    logic                           bypass_reg, bypass_next;

    logic                           accept;
    logic                           last_pix;
    logic                           emit;
    logic [fbb_pkg::FILL_W-1:0]     fill_inc;
    logic [fbb_pkg::FILL_W-1:0]     recip_idx;
    logic [fbb_pkg::ADDR_W-1:0]     wp_inc;
    logic [fbb_pkg::ADDR_W-1:0]     rp_inc;
    logic [fbb_pkg::WIN_CFG_W-1:0]  win_raw;
    logic [fbb_pkg::ROW_CFG_W-1:0]  row_raw;
    logic [fbb_pkg::FILL_W-1:0]     win_eff;
    logic [fbb_pkg::ROW_W-1:0]      row_eff;

    logic [fbb_pkg::RECIP_W-1:0]    recip_lut [fbb_pkg::MAX_WINDOW + 1];

    // ceil(2^k / n), worked out at elaboration
    assign recip_lut[0] = '0;
    for (genvar Div = 1; Div <= fbb_pkg::MAX_WINDOW; Div++)
    begin : g_recip
        assign recip_lut[Div] = fbb_pkg::RECIP_W'(
            ((64'd1 << fbb_pkg::RECIP_SHIFT) + 64'(Div) - 64'd1) / Div);
    end

    // a register write holds off requests for that cycle
    assign s_tready = (state_reg == S_IDLE) && !cfg_we;
    assign accept   = s_tvalid && s_tready;
    assign fill_inc = fill_reg + fbb_pkg::FILL_W'(1);
    assign last_pix = (fbb_pkg::ROW_W'(col_reg) + fbb_pkg::ROW_W'(1)) >= row_reg;
    assign emit     = fill_inc >= win_reg;
    assign wp_inc   = (wp_reg == fbb_pkg::ADDR_W'(fbb_pkg::MAX_WINDOW - 1)) ?
                      '0 : wp_reg + fbb_pkg::ADDR_W'(1);
    assign rp_inc   = (rp_reg == fbb_pkg::ADDR_W'(fbb_pkg::MAX_WINDOW - 1)) ?
                      '0 : rp_reg + fbb_pkg::ADDR_W'(1);
    assign recip_idx = accept ? fill_inc : fill_reg;

    assign win_raw = cfg_data[fbb_pkg::WIN_CFG_W-1:0];
    assign row_raw = cfg_data[fbb_pkg::ROW_CFG_W-1:0];

    always_comb
    begin
        if (win_raw == '0)
        begin
            win_eff = fbb_pkg::FILL_W'(1);
        end
        else if (32'(win_raw) > fbb_pkg::MAX_WINDOW)
        begin
            win_eff = fbb_pkg::FILL_W'(fbb_pkg::MAX_WINDOW);
        end
        else
        begin
            win_eff = fbb_pkg::FILL_W'(win_raw);
        end

        if (row_raw == '0)
        begin
            row_eff = fbb_pkg::ROW_W'(1);
        end
        else if (32'(row_raw) > fbb_pkg::MAX_ROW_WIDTH)
        begin
            row_eff = fbb_pkg::ROW_W'(fbb_pkg::MAX_ROW_WIDTH);
        end
        else
        begin
            row_eff = fbb_pkg::ROW_W'(row_raw);
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        win_next    = win_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        fill_next   = fill_reg;
        wp_next     = wp_reg;
        rp_next     = rp_reg;
        last_next   = last_reg;
        end_next    = end_reg;
        bypass_next = bypass_reg;

        lane_ctrl           = '0;
        lane_ctrl.wr_addr   = wp_reg;
        lane_ctrl.rd_addr   = rp_reg;
        lane_ctrl.bypass    = bypass_reg;
        lane_ctrl.recip     = recip_lut[recip_idx];
        out_ctrl.load       = 1'b0;
        out_ctrl.row_end    = end_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (cfg_we)
                begin
                    case (cfg_index)
                        CFG_WINDOW_SEL: win_next = win_eff;
                        CFG_ROW_SEL:    row_next = row_eff;
                        default:        win_next = win_reg;
                    endcase
                    // any write taken in idle restarts the row
                    col_next        = '0;
                    fill_next       = '0;
                    wp_next         = '0;
                    rp_next         = '0;
                    lane_ctrl.clear = 1'b1;
                end
                else if (accept)
                begin
                    lane_ctrl.wr_en  = 1'b1;
                    lane_ctrl.add_in = 1'b1;
                    wp_next          = wp_inc;
                    fill_next        = fill_inc;
                    last_next        = last_pix;
                    if (emit)
                    begin
                        lane_ctrl.rd_en     = 1'b1;
                        lane_ctrl.load_prod = 1'b1;
                        end_next            = last_pix && (fill_reg == '0);
                        bypass_next         = (rp_reg == wp_reg);
                        state_next          = S_POP;
                    end
                    else if (last_pix)
                    begin
                        state_next = S_READ;
                    end
                    else
                    begin
                        col_next = col_reg + fbb_pkg::COL_W'(1);
                    end
                end
            end

            S_READ:
            begin
                lane_ctrl.rd_en     = 1'b1;
                lane_ctrl.load_prod = 1'b1;
                end_next            = last_reg && (fill_reg == fbb_pkg::FILL_W'(1));
                bypass_next         = 1'b0;
                state_next          = S_POP;
            end

            S_POP:
            begin
                if (room)
                begin
                    out_ctrl.load     = 1'b1;
                    lane_ctrl.sub_out = 1'b1;
                    rp_next           = rp_inc;
                    fill_next         = fill_reg - fbb_pkg::FILL_W'(1);
                    if (last_reg && (fill_reg != fbb_pkg::FILL_W'(1)))
                    begin
                        state_next = S_READ;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                        if (last_reg)
                        begin
                            col_next = '0;
                            wp_next  = '0;
                            rp_next  = '0;
                        end
                        else
                        begin
                            col_next = col_reg + fbb_pkg::COL_W'(1);
                        end
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            win_reg    <= fbb_pkg::FILL_W'(fbb_pkg::WIN_RESET);
            row_reg    <= fbb_pkg::ROW_W'(fbb_pkg::ROW_RESET);
            col_reg    <= '0;
            fill_reg   <= '0;
            wp_reg     <= '0;
            rp_reg     <= '0;
            last_reg   <= 1'b0;
            end_reg    <= 1'b0;
            bypass_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            win_reg    <= win_next;
            row_reg    <= row_next;
            col_reg    <= col_next;
            fill_reg   <= fill_next;
            wp_reg     <= wp_next;
            rp_reg     <= rp_next;
            last_reg   <= last_next;
            end_reg    <= end_next;
            bypass_reg <= bypass_next;
        end
    end

    `FBB_ASSERT(a_fill_within_window, fill_reg <= win_reg)
    `FBB_ASSERT(a_col_within_row, fbb_pkg::ROW_W'(col_reg) < row_reg)
    `FBB_ASSERT(a_read_only_in_flush, (state_reg != S_READ) || (last_reg && (fill_reg != '0)))
    `FBB_ASSERT(a_pop_has_pixel, (state_reg != S_POP) || (fill_reg != '0))
    `FBB_ASSERT_NEXT(a_pop_mid_row_returns, (state_reg == S_POP) && room && !last_reg, state_reg == S_IDLE)

endmodule

FILE: sv/forward_row_box_blur.sv
// Forward row box blur: top level joining sequencer, channel lanes and output stage.
// An item that completes a window has its product registered in each lane, then its
// result loaded into the output register once there is room; no new pixel is accepted
// until that load (store read and one reciprocal multiply per lane). The last pixel of
// a row flushes each pending output in turn, as the flush shares the same lanes.
// Reset clears control and sums, sets window 8 and row width 640; the store is not cleared.
module forward_row_box_blur (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [fbb_pkg::TDATA_W-1:0]       s_tdata,   // red_in, green_in, blue_in
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [fbb_pkg::TDATA_W-1:0]       m_tdata,   // red_out, green_out, blue_out
    output logic                              m_tlast,
    input  logic                              cfg_we,
    input  logic [fbb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fbb_pkg::CFG_DATA_W-1:0]    cfg_data
);

    fbb_pkg::lane_ctrl_t                               lane_ctrl;
    fbb_pkg::out_ctrl_t                                out_ctrl;
    logic                                              room;
    logic [fbb_pkg::CHANNELS-1:0][fbb_pkg::PIX_W-1:0]  pix;
    logic [fbb_pkg::CHANNELS-1:0][fbb_pkg::PIX_W-1:0]  quot;

    assign pix = s_tdata;

    fbb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .room      (room),
        .lane_ctrl (lane_ctrl),
        .out_ctrl  (out_ctrl)
    );

    for (genvar ch = 0; ch < fbb_pkg::CHANNELS; ch++)
    begin : g_lane
        fbb_lane u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .pix   (pix[ch]),
            .ctrl  (lane_ctrl),
            .quot  (quot[ch])
        );
    end

    fbb_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .quot     (quot),
        .ctrl     (out_ctrl),
        .room     (room),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
